// ===== rtl/dorq_pkg.sv =====
package dorq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 32;
    localparam int ID_BITS     = 8;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_NONE_DUE = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] rel_time;
        logic [ID_BITS-1:0]   task_id;
    } entry_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_HEAD,
        RD_NEXT_HEAD,
        RD_TAIL_M1,
        RD_POS_M2
    } rd_sel_t;

    typedef struct packed {
        logic    latch;
        rd_sel_t rd_sel;
        logic    init_pos;
        logic    shift;
        logic    put;
        logic    pop;
        logic    drop_held;
        logic    emit;
        status_t emit_status;
        logic    emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic full;
        logic empty;
        logic due;
        logic later;
        logic rem_one;
        logic held;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/dorq_ram.sv =====
module dorq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/dorq_ctrl.sv =====
module dorq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dorq_pkg::dp_status_t stat,
    output dorq_pkg::dp_cmd_t   cmd
);
    import dorq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_CHECK     = 6'b000010,
        S_ADD_EVAL  = 6'b000100,
        S_ADD_PUT   = 6'b001000,
        S_RESP      = 6'b010000,
        S_TICK_EVAL = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   resp_full_reg, resp_full_next;
    logic   stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            resp_full_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            resp_full_reg <= resp_full_next;
        end
    end

    assign stall = (stat.held || !stat.due) && !stat.out_free;

    always_comb begin
        state_next      = state_reg;
        resp_full_next  = resp_full_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.rd_sel      = RD_NONE;
        cmd.emit_status = ST_ACCEPTED;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.is_tick) begin
                    cmd.rd_sel = RD_HEAD;
                    state_next = S_TICK_EVAL;
                end else if (stat.full) begin
                    resp_full_next = 1'b1;
                    state_next     = S_RESP;
                end else begin
                    resp_full_next = 1'b0;
                    cmd.init_pos   = 1'b1;
                    if (stat.empty) begin
                        state_next = S_ADD_PUT;
                    end else begin
                        cmd.rd_sel = RD_TAIL_M1;
                        state_next = S_ADD_EVAL;
                    end
                end
            end
            S_ADD_EVAL: begin
                if (stat.later) begin
                    cmd.shift = 1'b1;
                    if (stat.rem_one) begin
                        state_next = S_ADD_PUT;
                    end else begin
                        cmd.rd_sel = RD_POS_M2;
                    end
                end else begin
                    cmd.put    = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_ADD_PUT: begin
                cmd.put    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = resp_full_reg ? ST_FULL : ST_ACCEPTED;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_TICK_EVAL: begin
                if (!stall) begin
                    if (stat.held) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_RELEASED;
                        cmd.emit_last   = !stat.due;
                    end else if (!stat.due) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_NONE_DUE;
                        cmd.emit_last   = 1'b1;
                    end
                    if (stat.due) begin
                        cmd.pop    = 1'b1;
                        cmd.rd_sel = RD_NEXT_HEAD;
                    end else begin
                        cmd.drop_held = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/dorq_datapath.sv =====
module dorq_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_command,
    input  logic [dorq_pkg::TIME_BITS-1:0]   s_release_time,
    input  logic [dorq_pkg::ID_BITS-1:0]     s_task_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [dorq_pkg::ID_BITS-1:0]     m_released_id,
    output logic                             m_last,
    input  dorq_pkg::dp_cmd_t                cmd,
    output dorq_pkg::dp_status_t             stat
);
    import dorq_pkg::*;

    logic                 req_cmd_reg;
    logic [TIME_BITS-1:0] req_time_reg;
    logic [ID_BITS-1:0]   req_id_reg;
    logic [IDX_BITS-1:0]  head_reg, head_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [IDX_BITS-1:0]  pos_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic                 held_reg, held_next;
    logic [ID_BITS-1:0]   held_id_reg;
    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [ID_BITS-1:0]   m_id_reg;
    logic                 m_last_reg;

    logic [IDX_BITS-1:0]     tail;
    logic                    wr_en;
    logic [IDX_BITS-1:0]     rd_addr;
    logic                    rd_en;
    entry_t                  wr_entry;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t                  rd_entry;

    assign tail     = head_reg + count_reg[IDX_BITS-1:0];
    assign rd_entry = entry_t'(rd_data);

    always_comb begin
        case (cmd.rd_sel)
            RD_HEAD:      rd_addr = head_reg;
            RD_NEXT_HEAD: rd_addr = head_reg + IDX_BITS'(1);
            RD_TAIL_M1:   rd_addr = tail - IDX_BITS'(1);
            RD_POS_M2:    rd_addr = pos_reg - IDX_BITS'(2);
            default:      rd_addr = head_reg;
        endcase
    end

    assign rd_en    = (cmd.rd_sel != RD_NONE);
    assign wr_en    = cmd.shift || cmd.put;
    assign wr_entry = cmd.shift ? rd_entry : entry_t'{rel_time: req_time_reg, task_id: req_id_reg};

    dorq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(pos_reg),
        .wr_data(wr_entry),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        held_next  = held_reg;
        if (cmd.put) begin
            count_next = count_reg + CNT_BITS'(1);
        end
        if (cmd.pop) begin
            head_next  = head_reg + IDX_BITS'(1);
            count_next = count_reg - CNT_BITS'(1);
            held_next  = 1'b1;
        end
        if (cmd.drop_held) begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            held_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            req_cmd_reg  <= s_command;
            req_time_reg <= s_release_time;
            req_id_reg   <= s_task_id;
        end
        if (cmd.init_pos) begin
            pos_reg <= tail;
            rem_reg <= count_reg;
        end else if (cmd.shift) begin
            pos_reg <= pos_reg - IDX_BITS'(1);
            rem_reg <= rem_reg - CNT_BITS'(1);
        end
        if (cmd.pop) begin
            held_id_reg <= rd_entry.task_id;
        end
        if (cmd.emit) begin
            m_status_reg <= cmd.emit_status;
            m_id_reg     <= (cmd.emit_status == ST_RELEASED) ? held_id_reg : '0;
            m_last_reg   <= cmd.emit_last;
        end
    end

    assign stat.is_tick  = (req_cmd_reg == CMD_TICK);
    assign stat.full     = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.due      = !stat.empty && (rd_entry.rel_time <= req_time_reg);
    assign stat.later    = (rd_entry.rel_time > req_time_reg);
    assign stat.rem_one  = (rem_reg == CNT_BITS'(1));
    assign stat.held     = held_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_released_id = m_id_reg;
    assign m_last        = m_last_reg;
endmodule

// ===== rtl/deadline_ordered_release_queue.sv =====
// channel   direction  payload                                  handshake
// s_        in         command, release_time, task_id           s_valid / s_ready
// m_        out        status, released_id, last                m_valid / m_ready
//
// add: checks for room, then moves each stored task with a later release time up one slot (insertion shift
//   through the single-write entry ram), then writes the new task; a rejected add goes straight to the full response
// tick: pops and releases each due task in turn, the ram read of the next entry sets the pace
// reset clears the head, count, held flag, result valid and control state only; the entry ram needs no clearing pass
// a stalled result register holds the tick loop; s_ready is high only between requests
module deadline_ordered_release_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [dorq_pkg::TIME_BITS-1:0] s_release_time,
    input  logic [dorq_pkg::ID_BITS-1:0]   s_task_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [dorq_pkg::ID_BITS-1:0]   m_released_id,
    output logic                           m_last
);
    import dorq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    dorq_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    dorq_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_command     (s_command),
        .s_release_time(s_release_time),
        .s_task_id     (s_task_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_released_id (m_released_id),
        .m_last        (m_last),
        .cmd           (cmd),
        .stat          (stat)
    );
endmodule

// ===== rtl/dorq_checker.sv =====
module dorq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_command,
    input logic [dorq_pkg::TIME_BITS-1:0] s_release_time,
    input logic [dorq_pkg::ID_BITS-1:0]   s_task_id,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [1:0]                     m_status,
    input logic [dorq_pkg::ID_BITS-1:0]   m_released_id,
    input logic                           m_last
);
    import dorq_pkg::*;

    // reset empties the result register
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_released_id)
            && $stable(m_last))
        else $error("stalled result changed");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_RELEASED |-> m_last)
        else $error("non-release result without last");

    a_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_RELEASED |-> m_released_id == '0)
        else $error("non-release result with id");
endmodule

bind deadline_ordered_release_queue dorq_checker u_dorq_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dorq_pkg::*;

    localparam int MAX_RELEASE = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        status_t            status;
        logic [ID_BITS-1:0] released_id;
        logic               last;
    } result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_ADD;
    logic [TIME_BITS-1:0] s_release_time = '0;
    logic [ID_BITS-1:0]   s_task_id = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_status;
    logic [ID_BITS-1:0]   m_released_id;
    logic                 m_last;

    entry_t  pending_model[$];
    result_t expected_results[$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    logic [TIME_BITS-1:0] now_time = '0;

    deadline_ordered_release_queue u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_release_time (s_release_time),
        .s_task_id      (s_task_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_released_id  (m_released_id),
        .m_last         (m_last)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void push_result(status_t st, logic [ID_BITS-1:0] id, logic last);
        result_t r;
        r.status = st;
        r.released_id = id;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(logic cmd, logic [TIME_BITS-1:0] t,
                                            logic [ID_BITS-1:0] id);
        entry_t e;
        int pos;
        int n;
        if (cmd == CMD_ADD) begin
            if (pending_model.size() >= QUEUE_DEPTH) begin
                push_result(ST_FULL, '0, 1'b1);
            end else begin
                // ties keep arrival order
                pos = pending_model.size();
                while (pos > 0 && pending_model[pos-1].rel_time > t) pos--;
                e.rel_time = t;
                e.task_id = id;
                pending_model.insert(pos, e);
                push_result(ST_ACCEPTED, '0, 1'b1);
            end
        end else begin
            n = 0;
            while (n < pending_model.size() && n < MAX_RELEASE &&
                   pending_model[n].rel_time <= t) n++;
            if (n == 0) begin
                push_result(ST_NONE_DUE, '0, 1'b1);
            end else begin
                for (int j = 0; j < n; j++) begin
                    e = pending_model.pop_front();
                    push_result(ST_RELEASED, e.task_id, (j == n - 1));
                end
            end
        end
    endfunction

    function automatic void check_result();
        result_t exp_r;
        if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d released_id %0d last %0d",
                   m_status, m_released_id, m_last);
            fail_count++;
        end else begin
            exp_r = expected_results.pop_front();
            if (m_status !== exp_r.status) begin
                $error("status expected %0d actual %0d", exp_r.status, m_status);
                fail_count++;
            end
            if (m_released_id !== exp_r.released_id) begin
                $error("released_id expected %0d actual %0d", exp_r.released_id,
                       m_released_id);
                fail_count++;
            end
            if (m_last !== exp_r.last) begin
                $error("last expected %0d actual %0d", exp_r.last, m_last);
                fail_count++;
            end
        end
    endfunction

    // receiver: stall pattern switches among four random modes, plus long holds
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result();
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 64);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= cycle_count[0];
            endcase
        end
    end

    // offer one request and wait for it to be taken; valid stays high afterwards
    task automatic send_request(logic cmd, logic [TIME_BITS-1:0] t, logic [ID_BITS-1:0] id);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_release_time <= t;
        s_task_id <= id;
        do @(posedge aclk); while (!s_ready);
        predict_request(cmd, t, id);
    endtask

    task automatic issue(logic cmd, logic [TIME_BITS-1:0] t, logic [ID_BITS-1:0] id);
        int unsigned gap;
        send_request(cmd, t, id);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic test_directed();
        issue(CMD_TICK, 32'h0, 8'hFF);
        issue(CMD_ADD, 32'hFFFF_FFFF, 8'hFF);
        issue(CMD_ADD, 32'h0, 8'h00);
        issue(CMD_ADD, 32'd100, 8'h5A);
        issue(CMD_ADD, 32'd100, 8'hA5);
        issue(CMD_ADD, 32'd100, 8'h11);
        issue(CMD_ADD, 32'd50, 8'h07);
        issue(CMD_TICK, 32'd49, 8'h00);
        issue(CMD_TICK, 32'd49, 8'hFF);
        issue(CMD_TICK, 32'd100, 8'h00);
        issue(CMD_TICK, 32'hFFFF_FFFE, 8'h00);
        issue(CMD_TICK, 32'hFFFF_FFFF, 8'h00);
        issue(CMD_ADD, 32'h8000_0000, 8'h80);
        issue(CMD_ADD, 32'h7FFF_FFFF, 8'h7F);
        issue(CMD_TICK, 32'hFFFF_FFFF, 8'h55);
        // tie behind an earlier insertion
        issue(CMD_ADD, 32'd10, 8'h01);
        issue(CMD_ADD, 32'd5, 8'h02);
        issue(CMD_ADD, 32'd10, 8'h03);
        issue(CMD_TICK, 32'd10, 8'hAA);
        issue(CMD_TICK, 32'd10, 8'h00);
    endtask

    task automatic test_full_store();
        while (pending_model.size() < QUEUE_DEPTH)
            issue(CMD_ADD, 1000 - pending_model.size() * 10 + $urandom_range(0, 15),
                  ID_BITS'($urandom_range(0, 255)));
        issue(CMD_ADD, 32'd0, 8'hFF);
        issue(CMD_ADD, 32'hFFFF_FFFF, 8'h00);
        issue(CMD_TICK, 32'hFFFF_FFFF, 8'h00);
        now_time = '0;
    endtask

    task automatic test_backpressure();
        hold_asked++;
        for (int k = 0; k < 40; k++)
            send_request(CMD_ADD, now_time + $urandom_range(0, 50),
                         ID_BITS'($urandom_range(0, 255)));
        send_request(CMD_TICK, now_time + 50, 8'h00);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_random(int unsigned count);
        int unsigned pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                issue(CMD_ADD, now_time + $urandom_range(0, 300),
                      ID_BITS'($urandom_range(0, 255)));
            end else if (pick < 60) begin
                issue(CMD_ADD, $urandom(), ID_BITS'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                now_time = now_time + $urandom_range(0, 150);
                issue(CMD_TICK, now_time, ID_BITS'($urandom_range(0, 255)));
            end else begin
                issue(CMD_TICK, $urandom(), ID_BITS'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_store();
        test_backpressure();
        test_random(250);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
